>>> rtl/kft_pkg.sv
`timescale 1ns / 1ps
package kft_pkg;

  localparam int FRAC_BITS = 16;
  localparam int STATE_COUNT = 3;
  localparam int DW = 32;
  localparam int PROD_W = 2 * (DW + 1);
  localparam int ACC_W = DW + 20;
  localparam int DIV_W = DW + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int UOP_IDX_W = 4;

  // config register indexes
  localparam logic [1:0] REG_STEP_TIME = 2'd0;
  localparam logic [1:0] REG_PROC_NOISE = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE = 2'd2;

  // reset values
  localparam logic [16:0] STEP_TIME_RST = 17'd1311;
  localparam logic [30:0] PROC_NOISE_RST = 31'd26214400;
  localparam logic [30:0] MEAS_NOISE_RST = 31'd655360;
  localparam logic signed [31:0] X0_RST = 32'sd0;
  localparam logic signed [31:0] X1_RST = 32'sd19661;
  localparam logic signed [31:0] X2_RST = 32'sd2949120;
  localparam logic signed [31:0] PDIAG_RST = 32'sd3276800;

  // last micro-op of predict, and first and last micro-op of update
  localparam logic [UOP_IDX_W-1:0] UOP_PRED_LAST = 4'd5;
  localparam logic [UOP_IDX_W-1:0] UOP_UPD_FIRST = 4'd6;
  localparam logic [UOP_IDX_W-1:0] UOP_UPD_LAST = 4'd14;

  typedef enum logic [2:0] {
    A_ZERO,
    A_DT,
    A_G0,
    A_G1,
    A_G2
  } a_sel_t;

  typedef enum logic [3:0] {
    R_X0,
    R_X1,
    R_X2,
    R_P00,
    R_P01,
    R_P02,
    R_P11,
    R_P12,
    R_P22,
    R_N01,
    R_Y
  } reg_sel_t;

  typedef enum logic [1:0] {
    ACC_ADD,
    ACC_SUB,
    ACC_CONT
  } acc_op_t;

  typedef struct packed {
    a_sel_t   a_sel;
    reg_sel_t b_sel;
    reg_sel_t base_sel;
    acc_op_t  acc_op;
    reg_sel_t dest;
    logic     wr;
  } uop_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       acc;
    logic       wr;
    logic       noise;
    logic       setup;
    logic       div_start;
    logic       div_wr;
    logic       out_ld;
    logic [1:0] gsel;
    uop_t       uop;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  // micro-op program: predict steps then update steps
  function automatic uop_t uop_rom(input logic [UOP_IDX_W-1:0] idx);
    uop_t u;
    u = '{A_ZERO, R_X0, R_X0, ACC_ADD, R_X0, 1'b0};
    case (idx)
      4'd0:  u = '{A_DT, R_X1, R_X0, ACC_ADD, R_X0, 1'b1};
      4'd1:  u = '{A_DT, R_P11, R_P01, ACC_ADD, R_N01, 1'b1};
      4'd2:  u = '{A_DT, R_P01, R_P00, ACC_ADD, R_P00, 1'b0};
      4'd3:  u = '{A_DT, R_N01, R_P00, ACC_CONT, R_P00, 1'b1};
      4'd4:  u = '{A_DT, R_P12, R_P02, ACC_ADD, R_P02, 1'b1};
      4'd5:  u = '{A_ZERO, R_X0, R_N01, ACC_ADD, R_P01, 1'b1};
      4'd6:  u = '{A_G0, R_Y, R_X0, ACC_ADD, R_X0, 1'b1};
      4'd7:  u = '{A_G1, R_Y, R_X1, ACC_ADD, R_X1, 1'b1};
      4'd8:  u = '{A_G2, R_Y, R_X2, ACC_ADD, R_X2, 1'b1};
      4'd9:  u = '{A_G0, R_P02, R_P00, ACC_SUB, R_P00, 1'b1};
      4'd10: u = '{A_G0, R_P12, R_P01, ACC_SUB, R_P01, 1'b1};
      4'd11: u = '{A_G1, R_P12, R_P11, ACC_SUB, R_P11, 1'b1};
      4'd12: u = '{A_G0, R_P22, R_P02, ACC_SUB, R_P02, 1'b1};
      4'd13: u = '{A_G1, R_P22, R_P12, ACC_SUB, R_P12, 1'b1};
      4'd14: u = '{A_G2, R_P22, R_P22, ACC_SUB, R_P22, 1'b1};
      default: u = '{A_ZERO, R_X0, R_X0, ACC_ADD, R_X0, 1'b0};
    endcase
    return u;
  endfunction

endpackage

>>> rtl/kalman_filter_three_state_core.sv
// 15 multiply-accumulate steps (multiply, accumulate, write) on one shared 33x33
// multiplier, three gain divisions (start, 48 radix-2 steps, done, write), noise,
// setup and result load states
// a new input is taken only in idle; a stalled result holds only the final result load
// reset: synchronous active-low; state returns to its initial estimate and covariance
`timescale 1ns / 1ps
module kalman_filter_three_state_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_measured_angle,
  input  logic               in_add_noise,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_est_position,
  output logic signed [31:0] out_est_velocity,
  output logic signed [31:0] out_est_angle,
  output logic [30:0]        out_angle_variance,
  output logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import kft_pkg::*;

  logic [16:0] step_time_r;
  logic [30:0] proc_noise_r;
  logic [30:0] meas_noise_r;
  logic        cfg_wr;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  // register writes
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r  <= STEP_TIME_RST;
      proc_noise_r <= PROC_NOISE_RST;
      meas_noise_r <= MEAS_NOISE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_STEP_TIME:  step_time_r  <= pwdata[16:0];
        REG_PROC_NOISE: proc_noise_r <= pwdata[30:0];
        REG_MEAS_NOISE: meas_noise_r <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      REG_STEP_TIME:  prdata = {15'd0, step_time_r};
      REG_PROC_NOISE: prdata = {1'b0, proc_noise_r};
      REG_MEAS_NOISE: prdata = {1'b0, meas_noise_r};
      default:        prdata = '0;
    endcase
  end

  kft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  kft_dp u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .stat                    (stat),
    .step_time               (step_time_r),
    .angle_process_noise     (proc_noise_r),
    .angle_measurement_noise (meas_noise_r),
    .measured_angle          (in_measured_angle),
    .add_noise               (in_add_noise),
    .est_position            (out_est_position),
    .est_velocity            (out_est_velocity),
    .est_angle               (out_est_angle),
    .angle_variance          (out_angle_variance),
    .saturated               (out_saturated)
  );

endmodule

>>> rtl/kft_div.sv
`timescale 1ns / 1ps
module kft_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [31:0]   num,
  input  logic [32:0]          den,
  output logic                 done,
  output logic signed [31:0]   gain,
  output logic                 clip
);
  import kft_pkg::*;

  logic [DIV_W-1:0]     dvd_r;
  logic [DIV_W-1:0]     q_r;
  logic [33:0]          rem_r;
  logic [32:0]          den_r;
  logic                 neg_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  logic [32:0]      mag;
  logic [DIV_W-1:0] dividend;
  logic [33:0]      rem_sh;
  logic [34:0]      diff;
  logic             ge;

  // magnitude of numerator scaled up, plus half the divisor for rounding
  assign mag = num[31] ? (33'd0 - {num[31], num}) : {num[31], num};
  assign dividend = {mag[31:0], {FRAC_BITS{1'b0}}} + DIV_W'(den[32:1]);

  // one quotient bit per cycle
  assign rem_sh = {rem_r[32:0], dvd_r[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge     = ~diff[34];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      q_r   <= '0;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[31];
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      q_r   <= {q_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[33:0] : rem_sh;
    end
  end

  // sign and saturate the quotient
  always_comb begin
    clip = 1'b0;
    if (!neg_r) begin
      if (q_r > DIV_W'(32'h7FFF_FFFF)) begin
        clip = 1'b1;
        gain = 32'sh7FFF_FFFF;
      end else begin
        gain = signed'(q_r[31:0]);
      end
    end else begin
      if (q_r > DIV_W'(33'h0_8000_0000)) begin
        clip = 1'b1;
        gain = 32'sh8000_0000;
      end else begin
        gain = signed'(32'd0 - q_r[31:0]);
      end
    end
  end

  assign done = done_r;

endmodule

>>> rtl/kft_dp.sv
`timescale 1ns / 1ps
module kft_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  kft_pkg::dp_cmd_t    cmd,
  output kft_pkg::dp_stat_t   stat,
  input  logic [16:0]         step_time,
  input  logic [30:0]         angle_process_noise,
  input  logic [30:0]         angle_measurement_noise,
  input  logic signed [31:0]  measured_angle,
  input  logic                add_noise,
  output logic signed [31:0]  est_position,
  output logic signed [31:0]  est_velocity,
  output logic signed [31:0]  est_angle,
  output logic [30:0]         angle_variance,
  output logic                saturated
);
  import kft_pkg::*;

  logic signed [31:0] x0_r, x1_r, x2_r;
  logic signed [31:0] p00_r, p01_r, p02_r, p11_r, p12_r, p22_r;
  logic signed [31:0] n01_r, g0_r, g1_r, g2_r, z_r;
  logic signed [32:0] y_r;
  logic [32:0]        s_r;
  logic               noise_r;
  logic               clip_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [31:0] pos_out_r, vel_out_r, ang_out_r;
  logic [30:0]        var_out_r;
  logic               sat_out_r;

  logic signed [32:0]       a_op, b_op;
  logic signed [31:0]       base_v;
  logic signed [PROD_W-1:0] rnd_full;
  logic signed [ACC_W-1:0]  rnd_v, base_x, acc_nxt;
  logic signed [31:0]       sat_v;
  logic                     sat_clip;
  logic signed [33:0]       noise_sum;
  logic signed [31:0]       noise_v;
  logic                     noise_clip;
  logic [30:0]              meas_eff;
  logic signed [33:0]       s_sum;
  logic signed [31:0]       div_num;
  logic                     div_done;
  logic signed [31:0]       div_gain;
  logic                     div_clip;

  // multiplier operand a
  always_comb begin
    case (cmd.uop.a_sel)
      A_ZERO:  a_op = '0;
      A_DT:    a_op = signed'({16'd0, step_time});
      A_G0:    a_op = 33'(g0_r);
      A_G1:    a_op = 33'(g1_r);
      A_G2:    a_op = 33'(g2_r);
      default: a_op = '0;
    endcase
  end

  // multiplier operand b
  always_comb begin
    case (cmd.uop.b_sel)
      R_X0:    b_op = 33'(x0_r);
      R_X1:    b_op = 33'(x1_r);
      R_X2:    b_op = 33'(x2_r);
      R_P00:   b_op = 33'(p00_r);
      R_P01:   b_op = 33'(p01_r);
      R_P02:   b_op = 33'(p02_r);
      R_P11:   b_op = 33'(p11_r);
      R_P12:   b_op = 33'(p12_r);
      R_P22:   b_op = 33'(p22_r);
      R_N01:   b_op = 33'(n01_r);
      R_Y:     b_op = y_r;
      default: b_op = '0;
    endcase
  end

  // accumulator base
  always_comb begin
    case (cmd.uop.base_sel)
      R_X0:    base_v = x0_r;
      R_X1:    base_v = x1_r;
      R_X2:    base_v = x2_r;
      R_P00:   base_v = p00_r;
      R_P01:   base_v = p01_r;
      R_P02:   base_v = p02_r;
      R_P11:   base_v = p11_r;
      R_P12:   base_v = p12_r;
      R_P22:   base_v = p22_r;
      R_N01:   base_v = n01_r;
      default: base_v = '0;
    endcase
  end

  // round product to nearest, ties up
  assign rnd_full = (prod_r + PROD_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign rnd_v    = rnd_full[ACC_W-1:0];
  assign base_x   = ACC_W'(base_v);

  always_comb begin
    case (cmd.uop.acc_op)
      ACC_ADD:  acc_nxt = base_x + rnd_v;
      ACC_SUB:  acc_nxt = base_x - rnd_v;
      ACC_CONT: acc_nxt = acc_r + rnd_v;
      default:  acc_nxt = acc_r;
    endcase
  end

  // saturate accumulator to 32 bits
  always_comb begin
    sat_clip = 1'b0;
    sat_v    = acc_r[31:0];
    if (acc_r > ACC_W'(32'sh7FFF_FFFF)) begin
      sat_clip = 1'b1;
      sat_v    = 32'sh7FFF_FFFF;
    end else if (acc_r < ACC_W'(32'sh8000_0000)) begin
      sat_clip = 1'b1;
      sat_v    = 32'sh8000_0000;
    end
  end

  // process noise on angle variance
  assign noise_sum = 34'(p22_r) + signed'({3'b000, angle_process_noise});
  always_comb begin
    noise_clip = 1'b0;
    noise_v    = noise_sum[31:0];
    if (noise_sum > 34'sh0_7FFF_FFFF) begin
      noise_clip = 1'b1;
      noise_v    = 32'sh7FFF_FFFF;
    end
  end

  // innovation divisor, never below one
  assign meas_eff = (angle_measurement_noise == '0) ? 31'd1 : angle_measurement_noise;
  assign s_sum    = 34'(p22_r) + signed'({3'b000, meas_eff});

  always_comb begin
    case (cmd.gsel)
      2'd0:    div_num = p02_r;
      2'd1:    div_num = p12_r;
      default: div_num = p22_r;
    endcase
  end

  kft_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (s_r),
    .done  (div_done),
    .gain  (div_gain),
    .clip  (div_clip)
  );

  assign stat.div_done = div_done;

  // multiply and accumulate
  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= a_op * b_op;
    if (cmd.acc) acc_r <= acc_nxt;
  end

  // per-item scratch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z_r     <= measured_angle;
      noise_r <= add_noise;
    end
    if (cmd.setup) begin
      y_r <= 33'(z_r) - 33'(x2_r);
      s_r <= (s_sum <= 34'sd0) ? 33'd1 : s_sum[32:0];
    end
    if (cmd.div_wr) begin
      case (cmd.gsel)
        2'd0:    g0_r <= div_gain;
        2'd1:    g1_r <= div_gain;
        default: g2_r <= div_gain;
      endcase
    end
    if (cmd.wr && cmd.uop.wr && cmd.uop.dest == R_N01) n01_r <= sat_v;
  end

  // filter state and clip flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r   <= X0_RST;
      x1_r   <= X1_RST;
      x2_r   <= X2_RST;
      p00_r  <= PDIAG_RST;
      p01_r  <= '0;
      p02_r  <= '0;
      p11_r  <= PDIAG_RST;
      p12_r  <= '0;
      p22_r  <= PDIAG_RST;
      clip_r <= 1'b0;
    end else begin
      if (cmd.load) clip_r <= 1'b0;
      if (cmd.noise && noise_r) begin
        p22_r <= noise_v;
        if (noise_clip) clip_r <= 1'b1;
      end
      if (cmd.div_wr && div_clip) clip_r <= 1'b1;
      if (cmd.wr && cmd.uop.wr) begin
        if (sat_clip) clip_r <= 1'b1;
        case (cmd.uop.dest)
          R_X0:    x0_r <= sat_v;
          R_X1:    x1_r <= sat_v;
          R_X2:    x2_r <= sat_v;
          R_P00:   p00_r <= sat_v;
          R_P01:   p01_r <= sat_v;
          R_P02:   p02_r <= sat_v;
          R_P11:   p11_r <= sat_v;
          R_P12:   p12_r <= sat_v;
          R_P22:   p22_r <= sat_v;
          default: ;
        endcase
      end
    end
  end

  // result registers, loaded when no result is pending or the pending one transfers
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      pos_out_r <= x0_r;
      vel_out_r <= x1_r;
      ang_out_r <= x2_r;
      var_out_r <= p22_r[31] ? 31'd0 : p22_r[30:0];
      sat_out_r <= clip_r;
    end
  end

  assign est_position   = pos_out_r;
  assign est_velocity   = vel_out_r;
  assign est_angle      = ang_out_r;
  assign angle_variance = var_out_r;
  assign saturated      = sat_out_r;

endmodule

>>> rtl/kft_ctrl.sv
`timescale 1ns / 1ps
module kft_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output kft_pkg::dp_cmd_t   cmd,
  input  kft_pkg::dp_stat_t  stat
);
  import kft_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MUL    = 10'b0000000010,
    S_ACC    = 10'b0000000100,
    S_WR     = 10'b0000001000,
    S_NOISE  = 10'b0000010000,
    S_SETUP  = 10'b0000100000,
    S_DSTART = 10'b0001000000,
    S_DWAIT  = 10'b0010000000,
    S_DWRITE = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [UOP_IDX_W-1:0]   idx_r, idx_nxt;
  logic [1:0]             gsel_r, gsel_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   in_xfer;
  logic                   out_free;

  assign in_xfer  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    gsel_nxt      = gsel_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          idx_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = S_WR;
      S_WR: begin
        if (idx_r == UOP_PRED_LAST) begin
          state_nxt = S_NOISE;
        end else if (idx_r == UOP_UPD_LAST) begin
          state_nxt = S_OUT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_NOISE: state_nxt = S_SETUP;
      S_SETUP: begin
        gsel_nxt  = 2'd0;
        state_nxt = S_DSTART;
      end
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (stat.div_done) state_nxt = S_DWRITE;
      end
      S_DWRITE: begin
        if (gsel_r == 2'd2) begin
          idx_nxt   = UOP_UPD_FIRST;
          state_nxt = S_MUL;
        end else begin
          gsel_nxt  = gsel_r + 1'b1;
          state_nxt = S_DSTART;
        end
      end
      // wait until the result registers are free
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      gsel_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      gsel_r      <= gsel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath commands
  always_comb begin
    cmd.load      = in_xfer;
    cmd.mul       = (state_r == S_MUL);
    cmd.acc       = (state_r == S_ACC);
    cmd.wr        = (state_r == S_WR);
    cmd.noise     = (state_r == S_NOISE);
    cmd.setup     = (state_r == S_SETUP);
    cmd.div_start = (state_r == S_DSTART);
    cmd.div_wr    = (state_r == S_DWRITE);
    cmd.out_ld    = (state_r == S_OUT) && out_free;
    cmd.gsel      = gsel_r;
    cmd.uop       = uop_rom(idx_r);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
